FILE: rtl/core/agt_pkg.sv
// Shared types and constants for the anemometer speed and gust tracker.
package agt_pkg;

    localparam int GUST_SAMPLES = 64;
    localparam int RING_AW      = $clog2(GUST_SAMPLES);
    localparam int FILL_W       = $clog2(GUST_SAMPLES + 1);

    localparam int DIVIDEND_W   = 36;
    localparam int DIV_CNT_W    = $clog2(DIVIDEND_W + 1);

    localparam logic [19:0] ONE_SECOND_US = 20'd1_000_000;
    localparam logic [31:0] STALE_US      = 32'd2_000_000;

    localparam logic [15:0] SPEED_PER_TICK_RST = 16'd240;
    localparam logic [31:0] GUST_WINDOW_RST    = 32'd3000;
    localparam logic [15:0] SPEED_MAX          = 16'hFFFF;

    typedef enum logic [0:0] {
        CFG_SPEED_PER_TICK = 1'b0,
        CFG_GUST_WINDOW    = 1'b1
    } agt_cfg_idx_t;

    typedef enum logic [0:0] {
        CMD_TICK   = 1'b0,
        CMD_UPDATE = 1'b1
    } agt_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_WRITE,
        S_SCAN,
        S_DONE
    } agt_state_t;

    typedef struct packed {
        logic [31:0] stamp_ms;
        logic [15:0] speed;
    } agt_sample_t;

    typedef struct packed {
        logic wr_en;
        logic scan_start;
    } agt_ring_ctl_t;

endpackage

FILE: rtl/core/agt_divider.sv
// Bit-serial restoring divider that forms the saturated wind speed from a tick interval.
module agt_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] multiplicand,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [agt_pkg::DIV_CNT_W-1:0]  count_reg, count_next;
    logic [31:0]                    rem_reg, rem_next;
    logic [agt_pkg::DIVIDEND_W-1:0] dq_reg, dq_next;
    logic [31:0]                    divisor_reg, divisor_next;
    logic [agt_pkg::DIVIDEND_W-1:0] product;
    logic [32:0]                    trial;
    logic [32:0]                    diff;
    logic                           fits;

    assign product = agt_pkg::DIVIDEND_W'(multiplicand)
                   * agt_pkg::DIVIDEND_W'(agt_pkg::ONE_SECOND_US);
    assign trial   = {rem_reg, dq_reg[agt_pkg::DIVIDEND_W-1]};
    assign diff    = trial - {1'b0, divisor_reg};
    assign fits    = (trial >= {1'b0, divisor_reg});

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            count_next   = agt_pkg::DIV_CNT_W'(agt_pkg::DIVIDEND_W);
            rem_next     = '0;
            dq_next      = product;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            // The dividend shifts out at the top while quotient bits shift in at the bottom.
            rem_next   = fits ? diff[31:0] : trial[31:0];
            dq_next    = {dq_reg[agt_pkg::DIVIDEND_W-2:0], fits};
            count_next = count_reg - 1'b1;
            if (count_reg == agt_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = (|dq_reg[agt_pkg::DIVIDEND_W-1:16]) ? agt_pkg::SPEED_MAX : dq_reg[15:0];

endmodule

FILE: rtl/core/agt_ring.sv
// Gust sample ring: stores tick samples and scans them for the windowed maximum.
module agt_ring (
    input  logic                  clk,
    input  logic                  rst_n,
    input  agt_pkg::agt_ring_ctl_t ctl,
    input  logic [31:0]           time_ms,
    input  logic [15:0]           speed,
    input  logic [31:0]           window_ms,
    output logic                  scan_done,
    output logic [15:0]           best
);

    agt_pkg::agt_sample_t mem [agt_pkg::GUST_SAMPLES];

    logic [agt_pkg::RING_AW-1:0] write_pos_reg, write_pos_next;
    logic [agt_pkg::FILL_W-1:0]  fill_count_reg, fill_count_next;
    logic [agt_pkg::FILL_W-1:0]  scan_idx_reg, scan_idx_next;
    logic                        active_reg, active_next;
    logic                        rd_valid_reg, rd_valid_next;
    logic [15:0]                 best_reg, best_next;
    agt_pkg::agt_sample_t        rd_data_reg;
    logic                        issue;
    logic [31:0]                 age;
    logic                        hit;

    assign issue = active_reg && (scan_idx_reg < fill_count_reg);
    assign age   = time_ms - rd_data_reg.stamp_ms;
    assign hit   = (age <= window_ms) && (rd_data_reg.speed > best_reg);

    assign scan_done = active_reg && !issue && !rd_valid_reg;

    always_comb
    begin
        write_pos_next  = write_pos_reg;
        fill_count_next = fill_count_reg;
        scan_idx_next   = scan_idx_reg;
        active_next     = active_reg;
        rd_valid_next   = issue;
        best_next       = best_reg;

        if (ctl.wr_en)
        begin
            if (write_pos_reg == agt_pkg::RING_AW'(agt_pkg::GUST_SAMPLES - 1))
                write_pos_next = '0;
            else
                write_pos_next = write_pos_reg + 1'b1;
            if (fill_count_reg < agt_pkg::FILL_W'(agt_pkg::GUST_SAMPLES))
                fill_count_next = fill_count_reg + 1'b1;
        end

        if (ctl.scan_start)
        begin
            active_next   = 1'b1;
            scan_idx_next = '0;
            best_next     = '0;
        end
        else
        begin
            if (issue)
                scan_idx_next = scan_idx_reg + 1'b1;
            if (rd_valid_reg && hit)
                best_next = rd_data_reg.speed;
            if (scan_done)
                active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg  <= '0;
            fill_count_reg <= '0;
            scan_idx_reg   <= '0;
            active_reg     <= 1'b0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            write_pos_reg  <= write_pos_next;
            fill_count_reg <= fill_count_next;
            scan_idx_reg   <= scan_idx_next;
            active_reg     <= active_next;
            rd_valid_reg   <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[write_pos_reg].stamp_ms <= time_ms;
            mem[write_pos_reg].speed    <= speed;
        end
    end

    // Only entries below the fill count are read, and those have all been written.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[scan_idx_reg[agt_pkg::RING_AW-1:0]];
    end

    assign best = best_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= agt_pkg::FILL_W'(agt_pkg::GUST_SAMPLES))
        else $error("ring fill count above ring depth");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> !ctl.wr_en)
        else $error("sample write during gust scan");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(scan_idx_reg) < fill_count_reg)
        else $error("scan read beyond filled entries");

endmodule

FILE: rtl/core/anemometer_speed_gust_tracker.sv
// Top level of the anemometer speed and gust tracker with its item sequencer.
//
// Each transfer on the input channel is a tick or an update request and yields exactly one
// result transfer with the current wind speed and gust. The block takes one item at a time;
// a tick after an earlier tick with a nonzero interval forms its speed in the 36-step serial
// divider, and any other tick skips it. An update scans the sample memory one entry per
// cycle over the filled entries, at most those of a full 64-entry ring. A new item is
// accepted the cycle after the result is loaded into the output register, even while that
// result still waits to be taken.
module anemometer_speed_gust_tracker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [31:0] time_us,
    input  logic [31:0] time_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] wind_speed,
    output logic [15:0] gust_speed
);

    agt_pkg::agt_state_t state_reg, state_next;

    logic [15:0] speed_per_tick_reg;
    logic [31:0] gust_window_reg;

    logic        tick_seen_reg, tick_seen_next;
    logic [31:0] last_tick_us_reg, last_tick_us_next;
    logic [15:0] speed_now_reg, speed_now_next;
    logic [15:0] gust_now_reg, gust_now_next;
    logic [31:0] time_ms_reg, time_ms_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_wind_reg, out_wind_next;
    logic [15:0] out_gust_reg, out_gust_next;

    logic        accept;
    logic [31:0] span;
    logic        div_start;
    logic        div_done;
    logic [15:0] div_quotient;
    logic        scan_done;
    logic [15:0] scan_best;
    agt_pkg::agt_ring_ctl_t ring_ctl;

    assign in_ready = (state_reg == agt_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;
    assign span     = time_us - last_tick_us_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_per_tick_reg <= agt_pkg::SPEED_PER_TICK_RST;
            gust_window_reg    <= agt_pkg::GUST_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            case (agt_pkg::agt_cfg_idx_t'(cfg_index))
                agt_pkg::CFG_SPEED_PER_TICK: speed_per_tick_reg <= cfg_data[15:0];
                agt_pkg::CFG_GUST_WINDOW:    gust_window_reg    <= cfg_data;
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        tick_seen_next    = tick_seen_reg;
        last_tick_us_next = last_tick_us_reg;
        speed_now_next    = speed_now_reg;
        gust_now_next     = gust_now_reg;
        time_ms_next      = time_ms_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_wind_next     = out_wind_reg;
        out_gust_next     = out_gust_reg;
        div_start         = 1'b0;
        ring_ctl          = '0;

        case (state_reg)
            agt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    time_ms_next = time_ms;
                    if (agt_pkg::agt_cmd_t'(command) == agt_pkg::CMD_TICK)
                    begin
                        tick_seen_next    = 1'b1;
                        last_tick_us_next = time_us;
                        if (tick_seen_reg && (span != 32'd0))
                        begin
                            div_start  = 1'b1;
                            state_next = agt_pkg::S_DIV;
                        end
                        else
                            state_next = agt_pkg::S_WRITE;
                    end
                    else
                    begin
                        if (tick_seen_reg && (span > agt_pkg::STALE_US))
                            speed_now_next = '0;
                        ring_ctl.scan_start = 1'b1;
                        state_next          = agt_pkg::S_SCAN;
                    end
                end
            end
            agt_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    speed_now_next = div_quotient;
                    state_next     = agt_pkg::S_WRITE;
                end
            end
            agt_pkg::S_WRITE:
            begin
                ring_ctl.wr_en = 1'b1;
                state_next     = agt_pkg::S_DONE;
            end
            agt_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    gust_now_next = scan_best;
                    state_next    = agt_pkg::S_DONE;
                end
            end
            agt_pkg::S_DONE:
            begin
                // The result waits here only while the previous one is still unclaimed.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_wind_next  = speed_now_reg;
                    out_gust_next  = gust_now_reg;
                    state_next     = agt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = agt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= agt_pkg::S_IDLE;
            tick_seen_reg    <= 1'b0;
            last_tick_us_reg <= '0;
            speed_now_reg    <= '0;
            gust_now_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            tick_seen_reg    <= tick_seen_next;
            last_tick_us_reg <= last_tick_us_next;
            speed_now_reg    <= speed_now_next;
            gust_now_reg     <= gust_now_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_ms_reg  <= time_ms_next;
        out_wind_reg <= out_wind_next;
        out_gust_reg <= out_gust_next;
    end

    agt_divider u_divider (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_start),
        .multiplicand (speed_per_tick_reg),
        .divisor      (span),
        .done         (div_done),
        .quotient     (div_quotient)
    );

    agt_ring u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ring_ctl),
        .time_ms   (time_ms_reg),
        .speed     (speed_now_reg),
        .window_ms (gust_window_reg),
        .scan_done (scan_done),
        .best      (scan_best)
    );

    assign out_valid  = out_valid_reg;
    assign wind_speed = out_wind_reg;
    assign gust_speed = out_gust_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == agt_pkg::S_DIV)
        else $error("divider finished outside the divide state");

    a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |-> state_reg == agt_pkg::S_SCAN)
        else $error("gust scan finished outside the scan state");

    a_update_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command) |=> state_reg == agt_pkg::S_SCAN)
        else $error("update transfer did not start a gust scan");

    a_tick_keeps_gust: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == agt_pkg::S_DIV || state_reg == agt_pkg::S_WRITE) |-> $stable(gust_now_reg))
        else $error("gust changed while handling a tick");

endmodule
